>>> rtl/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg: shared types and constants of the syncword deframer
// Register indexes, reset values, queue sizing and the front-to-back word.
// ----------------------------------------------------------------------------
package sdf_pkg;

  localparam int SYNC_WORD_W = 64;
  localparam int SYNC_LEN_W  = 7;
  localparam int FRAME_LEN_W = 13;
  localparam int ERR_W       = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;

  // popcount is split into groups of eight bits
  localparam int GROUP_BITS  = 8;
  localparam int GROUP_CNT   = SYNC_WORD_W / GROUP_BITS;
  localparam int GROUP_SUM_W = 4;

  // queue between classifier and framer
  localparam int QUEUE_DEPTH = 8;
  localparam int QUEUE_PTR_W = 3;
  localparam int QUEUE_CNT_W = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SYNC_WORD    = 2'd0,
    REG_SYNC_LENGTH  = 2'd1,
    REG_FRAME_LENGTH = 2'd2,
    REG_MAX_ERRORS   = 2'd3
  } reg_index_t;

  localparam logic [SYNC_WORD_W-1:0] SYNC_WORD_RESET    = '0;
  localparam logic [SYNC_LEN_W-1:0]  SYNC_LENGTH_RESET  = 7'd32;
  localparam logic [FRAME_LEN_W-1:0] FRAME_LENGTH_RESET = 13'd256;
  localparam logic [ERR_W-1:0]       MAX_ERRORS_RESET   = 7'd3;

  typedef struct packed {
    logic [SYNC_WORD_W-1:0] sync_word;
    logic [SYNC_LEN_W-1:0]  sync_length;
    logic [FRAME_LEN_W-1:0] frame_length;
    logic [ERR_W-1:0]       max_sync_errors;
  } cfg_t;

  // one classified bit: the bit itself and the sync search outcome on it
  typedef struct packed {
    logic             data_bit;
    logic             sync_hit;
    logic [ERR_W-1:0] sync_errs;
  } class_t;

endpackage

>>> rtl/syncword_deframer.sv
// ----------------------------------------------------------------------------
// syncword_deframer: sync word correlator with error tolerance and deframer
// Finds a sync word in a bit stream within an error limit and streams out the
// payload bits of the frame that follows it.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: one received bit per word, taken on a
//   clock edge with push high and full low. Output side is a queue read port:
//   while empty is low the oldest payload word sits on frame_bit, first_bit,
//   last_bit and sync_errors; pop high takes it.
//   Bits outside a frame produce no output word; they only feed the search.
//   A payload bit that is accepted loads the first popcount stage, then the
//   second stage, the queue write and the output register load follow before
//   it shows on the outputs; a stalled receiver can hold the last load back.
//   Throughput: one bit per cycle sustained while pop keeps up; the popcount
//   pipeline and the framer each handle one word per cycle unless stalled.
//   full rises once eight words sit in the popcount pipeline and the queue,
//   so a stalled receiver backs up into the input after eight more bits.
//   Configuration writes (cfg_write, cfg_index, cfg_data) land at once and are
//   to be made while no word is in flight.
//   Reset: registers take their defaults (sync length 32, frame length 256,
//   error limit 3, sync word zero), history clears, framer goes idle.
//   No clearing pass; push is taken on the first cycle after reset.
// ----------------------------------------------------------------------------
module syncword_deframer #(
  parameter int MAX_FRAME_BITS = 4096,
  parameter int SYNC_BITS      = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_write,
  input  logic [sdf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sdf_pkg::CFG_DATA_W-1:0]  cfg_data,
  // bit input
  input  logic                            push,
  output logic                            full,
  input  logic                            data_bit,
  // payload output
  output logic                            empty,
  input  logic                            pop,
  output logic                            frame_bit,
  output logic                            first_bit,
  output logic                            last_bit,
  output logic [sdf_pkg::ERR_W-1:0]       sync_errors
);
  import sdf_pkg::*;

  cfg_t                   cfg;
  logic                   q_push;
  class_t                 q_in;
  logic                   q_pop;
  logic                   q_valid;
  class_t                 q_out;
  logic [QUEUE_CNT_W-1:0] q_count;

  // register file: plain writes, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_word       <= SYNC_WORD_RESET;
      cfg.sync_length     <= SYNC_LENGTH_RESET;
      cfg.frame_length    <= FRAME_LENGTH_RESET;
      cfg.max_sync_errors <= MAX_ERRORS_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_SYNC_WORD:    cfg.sync_word       <= cfg_data[SYNC_WORD_W-1:0];
        REG_SYNC_LENGTH:  cfg.sync_length     <= cfg_data[SYNC_LEN_W-1:0];
        REG_FRAME_LENGTH: cfg.frame_length    <= cfg_data[FRAME_LEN_W-1:0];
        REG_MAX_ERRORS:   cfg.max_sync_errors <= cfg_data[ERR_W-1:0];
        default: ;
      endcase
    end
  end

  // front: history shift and mismatch count, one bit per cycle while full is low
  sdf_front #(
    .SYNC_BITS (SYNC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .data_bit (data_bit),
    .cfg      (cfg),
    .q_count  (q_count),
    .full     (full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  // decoupling queue; slots are reserved by the front at accept time
  sdf_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .entry_in  (q_in),
    .pop       (q_pop),
    .valid     (q_valid),
    .entry_out (q_out),
    .count     (q_count)
  );

  // back: frame tracking and output register
  sdf_back #(
    .MAX_FRAME_BITS (MAX_FRAME_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .frame_length (cfg.frame_length),
    .q_valid      (q_valid),
    .q_entry      (q_out),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .frame_bit    (frame_bit),
    .first_bit    (first_bit),
    .last_bit     (last_bit),
    .sync_errors  (sync_errors)
  );

endmodule

>>> rtl/sdf_front.sv
// ----------------------------------------------------------------------------
// sdf_front: bit history and sync word correlator
// Shifts in each bit, counts mismatches in a two-stage popcount and pushes
// the classified word into the queue. Queue slots are reserved at accept.
// ----------------------------------------------------------------------------
module sdf_front #(
  parameter int SYNC_BITS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            data_bit,
  input  sdf_pkg::cfg_t                   cfg,
  input  logic [sdf_pkg::QUEUE_CNT_W-1:0] q_count,
  output logic                            full,
  output logic                            q_push,
  output sdf_pkg::class_t                 q_entry
);
  import sdf_pkg::*;

  logic                   accept;
  logic [SYNC_BITS-1:0]   history;
  logic [SYNC_BITS-1:0]   history_next;
  logic [SYNC_LEN_W-1:0]  slen;
  logic [SYNC_WORD_W-1:0] diff_next;
  logic                   s1_valid;
  logic                   s1_bit;
  logic [SYNC_WORD_W-1:0] s1_diff;
  logic [GROUP_SUM_W-1:0] part_next [GROUP_CNT];
  logic                   s2_valid;
  logic                   s2_bit;
  logic [GROUP_SUM_W-1:0] s2_part [GROUP_CNT];
  logic [ERR_W-1:0]       total;
  logic [QUEUE_CNT_W:0]   occupancy;

  // words in flight plus words queued
  assign occupancy = {1'b0, q_count} + (QUEUE_CNT_W+1)'(s1_valid)
                   + (QUEUE_CNT_W+1)'(s2_valid);
  assign full      = occupancy >= (QUEUE_CNT_W+1)'(QUEUE_DEPTH);
  assign accept    = push && !full;

  assign history_next = {history[SYNC_BITS-2:0], data_bit};
  assign slen = (cfg.sync_length > SYNC_LEN_W'(SYNC_BITS)) ? SYNC_LEN_W'(SYNC_BITS)
                                                             : cfg.sync_length;

  // outside the compared window, set sync word bits count as mismatches
  for (genvar i = 0; i < SYNC_WORD_W; i++) begin : g_diff
    if (i < SYNC_BITS) begin : g_hist
      assign diff_next[i] = (history_next[i] && (SYNC_LEN_W'(i) < slen))
                            ^ cfg.sync_word[i];
    end else begin : g_word
      assign diff_next[i] = cfg.sync_word[i];
    end
  end

  always_comb begin
    for (int g = 0; g < GROUP_CNT; g++) begin
      part_next[g] = '0;
      for (int b = 0; b < GROUP_BITS; b++) begin
        part_next[g] = part_next[g] + GROUP_SUM_W'(s1_diff[g*GROUP_BITS+b]);
      end
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < GROUP_CNT; g++) begin
      total = total + ERR_W'(s2_part[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history  <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      if (accept) begin
        history <= history_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bit  <= data_bit;
      s1_diff <= diff_next;
    end
    if (s1_valid) begin
      s2_bit  <= s1_bit;
      s2_part <= part_next;
    end
  end

  assign q_push            = s2_valid;
  assign q_entry.data_bit  = s2_bit;
  assign q_entry.sync_hit  = total <= cfg.max_sync_errors;
  assign q_entry.sync_errs = total;

  a_no_overbook: assert property (@(posedge clk) disable iff (rst)
    occupancy <= (QUEUE_CNT_W+1)'(QUEUE_DEPTH))
    else $error("front reserved more queue slots than exist");

endmodule

>>> rtl/sdf_fifo.sv
// ----------------------------------------------------------------------------
// sdf_fifo: short queue between classifier and framer
// Register-based circular buffer of classified words.
// ----------------------------------------------------------------------------
module sdf_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  sdf_pkg::class_t                 entry_in,
  input  logic                            pop,
  output logic                            valid,
  output sdf_pkg::class_t                 entry_out,
  output logic [sdf_pkg::QUEUE_CNT_W-1:0] count
);
  import sdf_pkg::*;

  class_t                 mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;

  assign valid     = count != '0;
  assign entry_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QUEUE_CNT_W'(1);
        2'b01:   count <= count - QUEUE_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry_in;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> count < QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue overflow");

  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue underflow");

endmodule

>>> rtl/sdf_back.sv
// ----------------------------------------------------------------------------
// sdf_back: frame state and output register
// Takes classified words, tracks the frame position and loads payload words
// into the output register.
// ----------------------------------------------------------------------------
module sdf_back #(
  parameter int MAX_FRAME_BITS = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [sdf_pkg::FRAME_LEN_W-1:0] frame_length,
  input  logic                            q_valid,
  input  sdf_pkg::class_t                 q_entry,
  output logic                            q_pop,
  input  logic                            pop,
  output logic                            empty,
  output logic                            frame_bit,
  output logic                            first_bit,
  output logic                            last_bit,
  output logic [sdf_pkg::ERR_W-1:0]       sync_errors
);
  import sdf_pkg::*;

  localparam int POS_W = $clog2(MAX_FRAME_BITS + 1);
  localparam int CMP_W = (POS_W > FRAME_LEN_W) ? POS_W : FRAME_LEN_W;

  logic [POS_W-1:0] len;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] position_next;
  logic [POS_W-1:0] pos_inc;
  logic             in_frame;
  logic             in_frame_next;
  logic             in_frame_mid;
  logic [ERR_W-1:0] held_errs;
  logic [ERR_W-1:0] held_errs_next;
  logic             emit;
  logic             step;
  logic             out_valid;

  assign len = (CMP_W'(frame_length) > CMP_W'(MAX_FRAME_BITS)) ? POS_W'(MAX_FRAME_BITS)
                                                               : POS_W'(frame_length);

  assign step    = q_valid && (!out_valid || pop);
  assign q_pop   = step;
  assign emit    = in_frame && (position < len);
  assign pos_inc = position + POS_W'(1);

  always_comb begin
    position_next  = position;
    held_errs_next = held_errs;
    in_frame_mid   = emit && (pos_inc != len);
    if (emit) begin
      position_next = pos_inc;
    end
    in_frame_next = in_frame_mid;
    // search runs whenever the word did not leave us inside a frame
    if (!in_frame_mid && q_entry.sync_hit) begin
      position_next  = '0;
      in_frame_next  = 1'b1;
      held_errs_next = q_entry.sync_errs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame  <= 1'b0;
      position  <= POS_W'(FRAME_LENGTH_RESET);
      held_errs <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        in_frame  <= in_frame_next;
        position  <= position_next;
        held_errs <= held_errs_next;
        out_valid <= emit;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      frame_bit   <= q_entry.data_bit;
      first_bit   <= position == '0;
      last_bit    <= pos_inc == len;
      sync_errors <= held_errs;
    end
  end

  assign empty = !out_valid;

  a_step_has_word: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("framer consumed a word from an empty queue");

endmodule
